// File: design/pps_pkg.sv
// Package for the prime/parity/sum classifier.
// Holds the word structs, fixed field widths, the first trial divisor and FSM state types.
// No dependencies.
package pps_pkg;

	// Fixed field widths
	localparam int VALUE_W     = 16;
	localparam int ODD_SUM_W   = 31;
	localparam int EVEN_SUM_W  = 30;
	localparam int PRIME_SUM_W = 31;

	// First trial divisor
	localparam int TRIAL_START = 2;

	// Input word
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               first;
		logic               last;
	} pps_item_t;

	// Result word
	typedef struct packed {
		logic                   is_odd;
		logic                   is_prime;
		logic [ODD_SUM_W-1:0]   odd_sum;
		logic [EVEN_SUM_W-1:0]  even_sum;
		logic [PRIME_SUM_W-1:0] prime_sum;
		logic                   end_of_run;
	} pps_result_t;

	// Running sums as one group
	typedef struct packed {
		logic [ODD_SUM_W-1:0]   odd_sum;
		logic [EVEN_SUM_W-1:0]  even_sum;
		logic [PRIME_SUM_W-1:0] prime_sum;
	} pps_sums_t;

	// Trial sequencer states
	typedef enum logic [1:0] {
		PT_IDLE,
		PT_CHECK,
		PT_DIV
	} pps_pt_state_t;

	// Top-level control states
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_TEST,
		TOP_COMMIT
	} pps_top_state_t;

endpackage

// File: design/pps_rem_serial.sv
// Bit-serial remainder unit: restoring division, one dividend bit per cycle.
// Depends on nothing but its parameters.
module pps_rem_serial #(
	parameter int DW = 16,
	parameter int JW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [JW-1:0] divisor,
	output logic          done,
	output logic          rem_zero
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] shreg_q;
	logic [JW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [JW:0]   rem_sh;
	logic [JW:0]   rem_n;

	// Shift in the next dividend bit and subtract the divisor when it fits
	always_comb begin
		rem_sh = {rem_q, shreg_q[DW-1]};
		if (rem_sh >= {1'b0, divisor}) begin
			rem_n = rem_sh - {1'b0, divisor};
		end else begin
			rem_n = rem_sh;
		end
	end

	// Control: bit counter, run flag, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= '0;
		end else if (run_q) begin
			shreg_q <= {shreg_q[DW-2:0], 1'b0};
			rem_q   <= rem_n[JW-1:0];
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

// File: design/pps_prime_test.sv
// Trial-division sequencer: steps divisors from 2 while j*j <= value.
// Depends on pps_pkg and pps_rem_serial.
module pps_prime_test #(
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] value,
	output logic          done,
	output logic          is_prime
);
	import pps_pkg::*;

	localparam int JW = (DW + 1) / 2 + 1;
	localparam int SW = DW + 2;

	pps_pt_state_t state_q, state_n;
	logic [DW-1:0] v_q;
	logic [JW-1:0] j_q;
	logic [SW-1:0] sq_q;
	logic          done_q;
	logic          prime_q;
	logic          rem_start;
	logic          rem_done;
	logic          rem_zero;
	logic          sq_over;

	pps_rem_serial #(.DW(DW), .JW(JW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (v_q),
		.divisor  (j_q),
		.done     (rem_done),
		.rem_zero (rem_zero)
	);

	assign sq_over = (sq_q > {2'b00, v_q});

	// Next state
	always_comb begin
		state_n   = state_q;
		rem_start = 1'b0;
		case (state_q)
			PT_IDLE: begin
				if (start && value >= DW'(TRIAL_START)) begin
					state_n = PT_CHECK;
				end
			end
			PT_CHECK: begin
				if (sq_over) begin
					state_n = PT_IDLE;
				end else begin
					rem_start = 1'b1;
					state_n   = PT_DIV;
				end
			end
			PT_DIV: begin
				if (rem_done) begin
					state_n = rem_zero ? PT_IDLE : PT_CHECK;
				end
			end
			default: state_n = PT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PT_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= ((state_q == PT_IDLE) && start && value < DW'(TRIAL_START))
				|| ((state_q == PT_CHECK) && sq_over)
				|| ((state_q == PT_DIV) && rem_done && rem_zero);
		end
	end

	// Divisor, its square and the verdict
	always_ff @(posedge clk) begin
		case (state_q)
			PT_IDLE: begin
				if (start) begin
					v_q     <= value;
					j_q     <= JW'(TRIAL_START);
					sq_q    <= SW'(TRIAL_START * TRIAL_START);
					prime_q <= 1'b0;
				end
			end
			PT_CHECK: begin
				if (sq_over) begin
					prime_q <= 1'b1;
				end
			end
			PT_DIV: begin
				if (rem_done && !rem_zero) begin
					// (j+1)^2 = j^2 + 2j + 1
					j_q  <= j_q + 1'b1;
					sq_q <= sq_q + SW'({j_q, 1'b1});
				end
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign is_prime = prime_q;

endmodule

// File: design/pps_accum.sv
// Saturating running sums of odd, even and prime values.
// Depends on pps_pkg.
module pps_accum #(
	parameter int DW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  logic                first,
	input  logic                is_odd,
	input  logic                is_prime,
	input  logic [DW-1:0]       value,
	output pps_pkg::pps_sums_t  sums_next
);
	import pps_pkg::*;

	localparam logic [31:0] ODD_MAX   = 32'((64'd1 << ODD_SUM_W) - 1);
	localparam logic [31:0] EVEN_MAX  = 32'((64'd1 << EVEN_SUM_W) - 1);
	localparam logic [31:0] PRIME_MAX = 32'((64'd1 << PRIME_SUM_W) - 1);

	pps_sums_t   sums_q;
	logic [31:0] add_v;
	logic [31:0] odd_s, even_s, prime_s;

	// Clear on first, add and clamp at all ones
	always_comb begin
		add_v   = 32'(value);
		odd_s   = (first ? 32'd0 : 32'(sums_q.odd_sum)) + add_v;
		even_s  = (first ? 32'd0 : 32'(sums_q.even_sum)) + add_v;
		prime_s = (first ? 32'd0 : 32'(sums_q.prime_sum)) + add_v;

		sums_next = first ? '0 : sums_q;
		if (is_odd) begin
			sums_next.odd_sum = (odd_s > ODD_MAX) ? ODD_MAX[ODD_SUM_W-1:0]
				: odd_s[ODD_SUM_W-1:0];
		end else begin
			sums_next.even_sum = (even_s > EVEN_MAX) ? EVEN_MAX[EVEN_SUM_W-1:0]
				: even_s[EVEN_SUM_W-1:0];
		end
		if (is_prime) begin
			sums_next.prime_sum = (prime_s > PRIME_MAX) ? PRIME_MAX[PRIME_SUM_W-1:0]
				: prime_s[PRIME_SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (commit) begin
			sums_q <= sums_next;
		end
	end

endmodule

// File: design/prime_parity_sum_classifier.sv
// Top level of the prime/parity/sum classifier.
// Depends on pps_pkg, pps_prime_test (with pps_rem_serial) and pps_accum.
//
//   channel | signals                          | payload
//   --------+----------------------------------+---------------------
//   item    | item_valid, item_ready           | item_data  (pps_item_t)
//   result  | res_valid,  res_ready            | res_data   (pps_result_t)
//
// One word at a time: a new word is taken only after the last one commits.
// Values below 2 skip trial division. Otherwise each trial divisor runs through
// the bit-serial remainder unit (DW is the used value width); a prime value
// takes one more divisor check, and at 16 bits up to 254 divisors are tried.
// Reset clears the sums, the control state and the result valid flag.
// A stalled result holds in its register; the next word is taken at once and
// only its commit waits until the held result leaves.
module prime_parity_sum_classifier #(
	parameter int VALUE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pps_pkg::pps_item_t   item_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output pps_pkg::pps_result_t res_data
);
	import pps_pkg::*;

	localparam int DW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	pps_top_state_t state_q, state_n;
	logic [DW-1:0]  v_q;
	logic           first_q;
	logic           last_q;
	logic           prime_q;
	logic           res_valid_q;
	pps_result_t    res_q;
	logic           accept;
	logic           commit;
	logic           pt_done;
	logic           pt_prime;
	pps_sums_t      sums_next;

	pps_prime_test #(.DW(DW)) u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.value    (item_data.value[DW-1:0]),
		.done     (pt_done),
		.is_prime (pt_prime)
	);

	pps_accum #(.DW(DW)) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.first     (first_q),
		.is_odd    (v_q[0]),
		.is_prime  (prime_q),
		.value     (v_q),
		.sums_next (sums_next)
	);

	// Next state and handshake
	always_comb begin
		state_n    = state_q;
		item_ready = 1'b0;
		commit     = 1'b0;
		case (state_q)
			TOP_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_n = TOP_TEST;
				end
			end
			TOP_TEST: begin
				if (pt_done) begin
					state_n = TOP_COMMIT;
				end
			end
			TOP_COMMIT: begin
				if (!res_valid_q || res_ready) begin
					commit  = 1'b1;
					state_n = TOP_IDLE;
				end
			end
			default: state_n = TOP_IDLE;
		endcase
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Hold the word, the verdict and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q     <= item_data.value[DW-1:0];
			first_q <= item_data.first;
			last_q  <= item_data.last;
		end
		if (pt_done) begin
			prime_q <= pt_prime;
		end
		if (commit) begin
			res_q.is_odd     <= v_q[0];
			res_q.is_prime   <= prime_q;
			res_q.odd_sum    <= sums_next.odd_sum;
			res_q.even_sum   <= sums_next.even_sum;
			res_q.prime_sum  <= sums_next.prime_sum;
			res_q.end_of_run <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: dv/tb_top.sv
// Testbench for prime_parity_sum_classifier: directed table, then random runs and loose words.
// Predicts each result word with its own trial-division and saturating-sum model.
// Depends on pps_pkg and the prime_parity_sum_classifier RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pps_pkg::*;

	localparam longint unsigned ODD_MAX   = (64'd1 << ODD_SUM_W) - 1;
	localparam longint unsigned EVEN_MAX  = (64'd1 << EVEN_SUM_W) - 1;
	localparam longint unsigned PRIME_MAX = (64'd1 << PRIME_SUM_W) - 1;
	localparam longint unsigned RUN_LIMIT_NS = 250_000_000;

	typedef struct {
		pps_item_t   word;
		bit          typed;
		pps_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	pps_item_t   item_data = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	pps_result_t res_data;

	// Model copy of the running sums
	logic [ODD_SUM_W-1:0]   odd_acc = '0;
	logic [EVEN_SUM_W-1:0]  even_acc = '0;
	logic [PRIME_SUM_W-1:0] prime_acc = '0;

	pps_result_t due_results[$];
	dir_row_t    dir_rows[$];
	int          mismatches = 0;
	int          words_sent = 0;
	bit          calm = 1'b0;

	prime_parity_sum_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data (item_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #10 clk = ~clk;

	// Trial division: divisors from 2 while j*j <= v and j does not divide v
	function automatic bit trial_prime(int unsigned v);
		int unsigned j;
		j = TRIAL_START;
		if (v < TRIAL_START) return 1'b0;
		while (j * j <= v && (v % j) != 0) j++;
		return j * j > v;
	endfunction

	function automatic longint unsigned sat_add(longint unsigned s, longint unsigned a,
			longint unsigned mx);
		return (s + a > mx) ? mx : s + a;
	endfunction

	// Classify one word and advance the model sums
	function automatic pps_result_t classify_and_sum(pps_item_t w);
		pps_result_t r;
		int unsigned v;
		bit          odd;
		bit          prime;
		v = w.value;
		odd = w.value[0];
		prime = trial_prime(v);
		if (w.first) begin
			odd_acc = '0;
			even_acc = '0;
			prime_acc = '0;
		end
		if (odd) odd_acc = ODD_SUM_W'(sat_add(odd_acc, v, ODD_MAX));
		else even_acc = EVEN_SUM_W'(sat_add(even_acc, v, EVEN_MAX));
		if (prime) prime_acc = PRIME_SUM_W'(sat_add(prime_acc, v, PRIME_MAX));
		r.is_odd = odd;
		r.is_prime = prime;
		r.odd_sum = odd_acc;
		r.even_sum = even_acc;
		r.prime_sum = prime_acc;
		r.end_of_run = w.last;
		return r;
	endfunction

	function automatic pps_item_t word_of(int unsigned v, bit f, bit l);
		pps_item_t w;
		w.value = VALUE_W'(v);
		w.first = f;
		w.last = l;
		return w;
	endfunction

	function automatic pps_result_t res_of(bit o, bit p, longint unsigned os,
			longint unsigned es, longint unsigned ps, bit eor);
		pps_result_t r;
		r.is_odd = o;
		r.is_prime = p;
		r.odd_sum = ODD_SUM_W'(os);
		r.even_sum = EVEN_SUM_W'(es);
		r.prime_sum = PRIME_SUM_W'(ps);
		r.end_of_run = eor;
		return r;
	endfunction

	task automatic add_row(int unsigned v, bit f, bit l, bit typed, pps_result_t want);
		dir_row_t row;
		row.word = word_of(v, f, l);
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Offer one word, idling at random first, and hold it until taken
	task automatic send_word(pps_item_t w);
		while (!calm && $urandom_range(0, 99) < 6) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// Predict, send, and queue the expected result word
	task automatic issue(pps_item_t w, bit typed, pps_result_t want);
		pps_result_t predicted;
		predicted = classify_and_sum(w);
		send_word(w);
		due_results.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	function automatic void check_field(string name, longint unsigned exp,
			longint unsigned act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	// Check each accepted result word and stall the result side at random
	always @(posedge clk) begin
		pps_result_t exp;
		if (res_valid && res_ready) begin
			if (due_results.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatches++;
			end else begin
				exp = due_results.pop_front();
				check_field("is_odd", exp.is_odd, res_data.is_odd);
				check_field("is_prime", exp.is_prime, res_data.is_prime);
				check_field("odd_sum", exp.odd_sum, res_data.odd_sum);
				check_field("even_sum", exp.even_sum, res_data.even_sum);
				check_field("prime_sum", exp.prime_sum, res_data.prime_sum);
				check_field("end_of_run", exp.end_of_run, res_data.end_of_run);
			end
		end
		res_ready <= calm || ($urandom_range(0, 99) >= 6);
	end

	initial begin
		int unsigned lim;
		int unsigned v;
		int unsigned cnt;

		// A proper run 0..7; the opening words are easy to work out by hand
		add_row(0, 1, 0, 1, res_of(0, 0, 0, 0, 0, 0));
		add_row(1, 0, 0, 1, res_of(1, 0, 1, 0, 0, 0));
		add_row(2, 0, 0, 1, res_of(0, 1, 1, 2, 2, 0));
		add_row(3, 0, 0, 1, res_of(1, 1, 4, 2, 5, 0));
		add_row(4, 0, 0, 0, '0);
		add_row(5, 0, 0, 0, '0);
		add_row(6, 0, 0, 0, '0);
		add_row(7, 0, 1, 0, '0);
		// Extremes of the value field and boundary squares
		add_row(65535, 1, 1, 1, res_of(1, 0, 65535, 0, 0, 1));
		add_row(65521, 0, 0, 0, '0);
		add_row(65534, 0, 0, 0, '0);
		add_row(63001, 0, 0, 0, '0);
		add_row(32768, 0, 0, 0, '0);
		add_row(16'h5555, 0, 0, 0, '0);
		add_row(16'hAAAA, 0, 0, 0, '0);
		add_row(16'h7FFF, 0, 0, 0, '0);
		// Last flag mid-stream without a first, then squares of primes
		add_row(9, 0, 1, 0, '0);
		add_row(49, 0, 0, 0, '0);
		// One and two clearing the sums, then zero adding nothing
		add_row(1, 1, 1, 1, res_of(1, 0, 1, 0, 0, 1));
		add_row(2, 1, 0, 1, res_of(0, 1, 0, 2, 2, 0));
		add_row(0, 0, 1, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

		// Mostly proper runs with random limits, the rest loose words
		while (words_sent < 130) begin
			calm = (words_sent >= 60 && words_sent < 100);
			if ($urandom_range(0, 3) != 0) begin
				lim = $urandom_range(1, 16);
				for (int unsigned k = 0; k <= lim; k++)
					issue(word_of(k, k == 0, k == lim), 1'b0, '0);
			end else begin
				cnt = $urandom_range(1, 4);
				repeat (cnt) begin
					v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 1023);
					issue(word_of(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
						1'b0, '0);
				end
			end
		end

		calm = 1'b0;
		issue(word_of(5, 1, 1), 1'b0, '0);
		item_valid <= 1'b0;

		// Drain, then let the block settle
		while (due_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("prime_parity_sum_classifier: match");
		else
			$display("prime_parity_sum_classifier: mismatch");
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("prime_parity_sum_classifier: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
design/pps_pkg.sv
design/pps_rem_serial.sv
design/pps_prime_test.sv
design/pps_accum.sv
design/prime_parity_sum_classifier.sv
dv/tb_top.sv
